// ===== src/tmp_pkg.sv =====
package tmp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PART_BITS  = 16;
    localparam int FRAC_W     = PART_BITS + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int MUL_W      = WORD_BITS + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = PROD_W;
    localparam int A_W        = WORD_BITS + FRAC_BITS;
    localparam int COMB_W     = A_W + WORD_BITS + 2;
    localparam int DIV_MAG_W  = A_W + 2;
    localparam int DIV_DEN_W  = WORD_BITS + 2;
    localparam int DIVIDEND_W = DIV_MAG_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_uword;
    typedef logic        [FRAC_W-1:0]    t_frac;

    localparam t_frac  FULL_FRAC    = FRAC_W'(1 << PART_BITS);
    localparam t_frac  FRAC_RST     = FULL_FRAC >> 2;
    localparam t_uword DURATION_RST = WORD_BITS'(1 << FRAC_BITS);
    localparam t_word  WORD_MAX     = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word  WORD_MIN     = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_VEL  = 3'd0,
        REG_END_VEL    = 3'd1,
        REG_ACCEL_FRAC = 3'd2,
        REG_DECEL_FRAC = 3'd3,
        REG_DURATION   = 3'd4,
        REG_GOAL       = 3'd5
    } t_reg_idx;

    typedef enum logic [4:0] {
        D_IDLE, D_TA, D_TD, D_CHK, D_N2, D_VM, D_VM_W, D_K1, D_K1_W,
        D_K3, D_K3_W, D_C2A, D_C2B, D_C2C, D_C2D, D_C2E, D_C2F, D_C3
    } t_drv_state;

    typedef struct packed {
        t_uword ta;
        t_uword td;
        t_word  vm;
        t_word  k1;
        t_word  k3;
        t_word  c2;
        t_word  c3;
        logic   err;
    } t_profile;

    typedef struct packed {
        logic                 go;
        logic                 neg;
        logic [DIV_MAG_W-1:0] mag;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word quo;
    } t_div_rsp;

    function automatic t_word sat_word(input logic signed [SUM_W-1:0] x);
        t_word res;
        if (x[SUM_W-1]) begin
            res = (&x[SUM_W-1:WORD_BITS-1]) ? x[WORD_BITS-1:0] : WORD_MIN;
        end else begin
            res = (|x[SUM_W-1:WORD_BITS-1]) ? WORD_MAX : x[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/trapezoid_motion_profile_core.sv =====
// query pipe: five registered stages, the result strobe comes from the fifth
// throughput: one query per cycle while busy is low; the receiver cannot stall and is never waited on
// a register write keeps busy high while the shared multiplier and the bit-serial
// divider derive the profile, using up to three 66-step divisions
// reset: registers return to their reset values, derived profile is all zero, pipe empty
module trapezoid_motion_profile_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tmp_pkg::WORD_BITS-1:0]   i_query_time,
    input  logic                            i_cfg_we,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tmp_pkg::WORD_BITS-1:0]   i_cfg_data,
    output logic                            o_valid,
    output logic signed [tmp_pkg::WORD_BITS-1:0] o_target_speed,
    output logic signed [tmp_pkg::WORD_BITS-1:0] o_target_place,
    output logic                            o_profile_error
);
    import tmp_pkg::*;

    t_word    r_start_vel;
    t_word    r_end_vel;
    t_frac    r_accel_frac;
    t_frac    r_decel_frac;
    t_uword   r_duration;
    t_word    r_goal;
    logic     r_go;
    logic     n_go;
    logic     drv_busy;
    logic     accept;
    t_profile prof;

    always_comb begin
        n_go = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_VEL, REG_END_VEL, REG_ACCEL_FRAC,
                REG_DECEL_FRAC, REG_DURATION, REG_GOAL: n_go = 1'b1;
                default:                                n_go = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vel  <= '0;
            r_end_vel    <= '0;
            r_accel_frac <= FRAC_RST;
            r_decel_frac <= FRAC_RST;
            r_duration   <= DURATION_RST;
            r_goal       <= '0;
            r_go         <= 1'b0;
        end else begin
            r_go <= n_go;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_VEL:  r_start_vel  <= i_cfg_data;
                    REG_END_VEL:    r_end_vel    <= i_cfg_data;
                    REG_ACCEL_FRAC: r_accel_frac <= i_cfg_data[FRAC_W-1:0];
                    REG_DECEL_FRAC: r_decel_frac <= i_cfg_data[FRAC_W-1:0];
                    REG_DURATION:   r_duration   <= i_cfg_data;
                    REG_GOAL:       r_goal       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    tmp_derive u_derive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_sv    (r_start_vel),
        .i_ev    (r_end_vel),
        .i_af    (r_accel_frac),
        .i_df    (r_decel_frac),
        .i_dur   (r_duration),
        .i_goal  (r_goal),
        .o_prof  (prof),
        .o_busy  (drv_busy)
    );

    // no request while a write is landing or the profile is being derived
    assign busy   = i_cfg_we | r_go | drv_busy;
    assign accept = start & ~busy;

    tmp_query_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_time  (i_query_time),
        .i_prof  (prof),
        .i_dur   (r_duration),
        .i_sv    (r_start_vel),
        .i_ev    (r_end_vel),
        .i_goal  (r_goal),
        .o_valid (o_valid),
        .o_speed (o_target_speed),
        .o_place (o_target_place),
        .o_err   (o_profile_error)
    );

endmodule

// ===== src/tmp_divider.sv =====
module tmp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmp_pkg::t_div_req i_req,
    output tmp_pkg::t_div_rsp o_rsp
);
    import tmp_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;
    logic                  r_ovf;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIV_DEN_W-1:0]  r_den;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [WORD_BITS:0]    r_quo;
    logic [DIV_DEN_W:0]    rem_sh;
    logic                  ge;
    t_uword                quo_neg;
    t_word                 quo_sat;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DIVIDEND_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, overflow past the word kept sticky
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_dvd <= {i_req.mag, {FRAC_BITS{1'b0}}};
            r_den <= i_req.den;
            r_neg <= i_req.neg;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= ge ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
            r_quo <= {r_quo[WORD_BITS-1:0], ge};
            r_ovf <= r_ovf | r_quo[WORD_BITS];
        end
    end

    always_comb begin
        quo_neg = -r_quo[WORD_BITS-1:0];
        if (r_ovf || r_quo[WORD_BITS]) begin
            quo_sat = r_neg ? WORD_MIN : WORD_MAX;
        end else if (r_neg) begin
            quo_sat = (r_quo[WORD_BITS-1] && (|r_quo[WORD_BITS-2:0])) ? WORD_MIN
                                                                       : t_word'(quo_neg);
        end else begin
            quo_sat = r_quo[WORD_BITS-1] ? WORD_MAX : t_word'(r_quo[WORD_BITS-1:0]);
        end
        o_rsp.done = r_done;
        o_rsp.quo  = quo_sat;
    end

endmodule

// ===== src/tmp_derive.sv =====
module tmp_derive (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  tmp_pkg::t_word    i_sv,
    input  tmp_pkg::t_word    i_ev,
    input  tmp_pkg::t_frac    i_af,
    input  tmp_pkg::t_frac    i_df,
    input  tmp_pkg::t_uword   i_dur,
    input  tmp_pkg::t_word    i_goal,
    output tmp_pkg::t_profile o_prof,
    output logic              o_busy
);
    import tmp_pkg::*;

    t_drv_state                r_state;
    t_drv_state                n_state;
    t_profile                  r_prof;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   r_lin;
    logic signed [SUM_W-1:0]   r_big;
    logic signed [A_W-1:0]     r_a;
    logic [2*WORD_BITS-1:0]    r_plo;

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic                      mul_en;
    logic signed [SUM_W-1:0]   div_num;
    logic signed [SUM_W-1:0]   div_abs;
    logic signed [SUM_W-1:0]   prod_q;
    logic signed [COMB_W-1:0]  comb;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    t_frac                     af_c;
    t_frac                     df_c;
    t_uword                    ta_len;
    t_uword                    td_len;
    t_uword                    cruise_len;
    logic                      prof_err;

    tmp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        af_c       = (i_af > FULL_FRAC) ? FULL_FRAC : i_af;
        df_c       = (i_df > FULL_FRAC) ? FULL_FRAC : i_df;
        ta_len     = r_prof.ta;
        td_len     = i_dur - r_prof.td;
        cruise_len = r_prof.td - r_prof.ta;
        prof_err   = (i_dur == '0) || (r_prof.ta > r_prof.td);
        prod_q     = SUM_W'(r_prod >>> FRAC_BITS);
        comb       = (COMB_W'(r_prod) <<< WORD_BITS) + COMB_W'({1'b0, r_plo});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_go) n_state = D_TA;
            D_TA:    n_state = D_TD;
            D_TD:    n_state = D_CHK;
            D_CHK:   n_state = D_N2;
            D_N2:    n_state = prof_err ? D_IDLE : D_VM;
            D_VM:    n_state = D_VM_W;
            D_VM_W:  if (div_rsp.done) n_state = D_K1;
            D_K1:    n_state = (ta_len != '0) ? D_K1_W : D_K3;
            D_K1_W:  if (div_rsp.done) n_state = D_K3;
            D_K3:    n_state = (i_dur > r_prof.td) ? D_K3_W : D_C2A;
            D_K3_W:  if (div_rsp.done) n_state = D_C2A;
            D_C2A:   n_state = D_C2B;
            D_C2B:   n_state = D_C2C;
            D_C2C:   n_state = D_C2D;
            D_C2D:   n_state = D_C2E;
            D_C2E:   n_state = D_C2F;
            D_C2F:   n_state = D_C3;
            D_C3:    n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // shared multiplier operands and divider request per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_en  = 1'b1;
        div_num = '0;
        div_req = '0;
        case (r_state)
            D_TA: begin
                mul_a = $signed({1'b0, i_dur});
                mul_b = $signed(MUL_W'(af_c));
            end
            D_TD: begin
                mul_a = $signed({1'b0, i_dur});
                mul_b = $signed(MUL_W'(df_c));
            end
            D_CHK: begin
                mul_a = $signed({1'b0, ta_len});
                mul_b = MUL_W'(i_sv);
            end
            D_N2: begin
                mul_a = $signed({1'b0, td_len});
                mul_b = MUL_W'(i_ev);
            end
            D_C2A: begin
                mul_a = MUL_W'($signed(r_prof.k1));
                mul_b = $signed({1'b0, ta_len});
            end
            D_C2B: begin
                mul_a = MUL_W'(i_sv);
                mul_b = $signed({1'b0, ta_len});
            end
            D_C2C: begin
                mul_a = $signed({1'b0, r_a[WORD_BITS-1:0]});
                mul_b = $signed({1'b0, ta_len});
            end
            D_C2D: begin
                mul_a = MUL_W'($signed(r_a[A_W-1:WORD_BITS]));
                mul_b = $signed({1'b0, ta_len});
            end
            D_C2E: begin
                mul_a = MUL_W'($signed(r_prof.vm));
                mul_b = $signed({1'b0, cruise_len});
            end
            D_VM: begin
                mul_en      = 1'b0;
                div_num     = r_acc - prod_q;
                div_req.go  = 1'b1;
                div_req.den = {2'b0, r_prof.td} - {2'b0, r_prof.ta} + {2'b0, i_dur};
            end
            D_K1: begin
                mul_en      = 1'b0;
                div_num     = SUM_W'($signed(r_prof.vm)) - SUM_W'(i_sv);
                div_req.go  = (ta_len != '0);
                div_req.den = {2'b0, ta_len};
            end
            D_K3: begin
                mul_en      = 1'b0;
                div_num     = SUM_W'(i_ev) - SUM_W'($signed(r_prof.vm));
                div_req.go  = (i_dur > r_prof.td);
                div_req.den = {2'b0, td_len};
            end
            default: mul_en = 1'b0;
        endcase
        div_abs     = div_num[SUM_W-1] ? -div_num : div_num;
        div_req.neg = div_num[SUM_W-1];
        div_req.mag = div_abs[DIV_MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_prof  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                D_TD:   r_prof.ta <= r_prod[FRAC_BITS +: WORD_BITS];
                D_CHK:  r_prof.td <= i_dur - r_prod[FRAC_BITS +: WORD_BITS];
                D_N2: begin
                    r_prof.err <= prof_err;
                    r_prof.vm  <= '0;
                    r_prof.k1  <= '0;
                    r_prof.k3  <= '0;
                    r_prof.c2  <= '0;
                    r_prof.c3  <= '0;
                end
                D_VM_W: if (div_rsp.done) r_prof.vm <= div_rsp.quo;
                D_K1_W: if (div_rsp.done) r_prof.k1 <= div_rsp.quo;
                D_K3_W: if (div_rsp.done) r_prof.k3 <= div_rsp.quo;
                D_C2F:  r_prof.c2 <= sat_word(r_lin + r_big);
                D_C3:   r_prof.c3 <= sat_word(SUM_W'($signed(r_prof.c2)) + prod_q);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (r_state)
            D_N2:  r_acc <= (SUM_W'(i_goal) <<< 1) - prod_q;
            D_C2B: r_a   <= r_prod[FRAC_BITS +: A_W];
            D_C2C: r_lin <= prod_q;
            D_C2D: r_plo <= r_prod[2*WORD_BITS-1:0];
            D_C2E: r_big <= SUM_W'(comb >>> (FRAC_BITS + 1));
            default: ;
        endcase
    end

    assign o_prof = r_prof;
    assign o_busy = (r_state != D_IDLE);

endmodule

// ===== src/tmp_query_pipe.sv =====
module tmp_query_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tmp_pkg::t_uword   i_time,
    input  tmp_pkg::t_profile i_prof,
    input  tmp_pkg::t_uword   i_dur,
    input  tmp_pkg::t_word    i_sv,
    input  tmp_pkg::t_word    i_ev,
    input  tmp_pkg::t_word    i_goal,
    output logic              o_valid,
    output tmp_pkg::t_word    o_speed,
    output tmp_pkg::t_word    o_place,
    output logic              o_err
);
    import tmp_pkg::*;

    // phase select
    t_uword u_sel;
    t_word  g_sel;
    t_word  h_sel;
    t_word  pb_sel;
    t_word  vb_sel;

    logic   r1_valid, r1_err;
    t_uword r1_u;
    t_word  r1_g, r1_h, r1_pb, r1_vb;

    logic                   r2_valid, r2_err;
    t_uword                 r2_u;
    logic signed [A_W-1:0]  r2_a, r2_hu;
    t_word                  r2_pb, r2_vb;

    logic                          r3_valid, r3_err;
    logic signed [A_W+MUL_W-WORD_BITS-1:0] r3_phi;
    logic [2*WORD_BITS-1:0]        r3_plo;
    logic signed [A_W-1:0]         r3_hu;
    t_word                         r3_pb, r3_v;

    logic                    r4_valid, r4_err;
    logic signed [SUM_W-1:0] r4_b, r4_lin;
    t_word                   r4_v;

    logic  r5_valid, r5_err;
    t_word r5_v, r5_p;

    logic signed [2*WORD_BITS:0] m_g, m_h;
    logic signed [COMB_W-1:0]    comb;

    always_comb begin
        u_sel  = '0;
        g_sel  = '0;
        h_sel  = '0;
        pb_sel = '0;
        vb_sel = '0;
        if (i_prof.err) begin
            u_sel = '0;
        end else if (i_time < i_prof.ta) begin
            u_sel  = i_time;
            g_sel  = i_prof.k1;
            h_sel  = i_sv;
            vb_sel = i_sv;
        end else if (i_time == i_prof.ta) begin
            pb_sel = i_prof.c2;
            vb_sel = i_prof.vm;
        end else if (i_time <= i_prof.td) begin
            vb_sel = i_prof.vm;
            if (i_time == i_prof.td) begin
                pb_sel = i_prof.c3;
            end else begin
                pb_sel = i_prof.c2;
                h_sel  = i_prof.vm;
                u_sel  = i_time - i_prof.ta;
            end
        end else if (i_time < i_dur) begin
            u_sel  = i_time - i_prof.td;
            g_sel  = i_prof.k3;
            h_sel  = i_prof.vm;
            pb_sel = i_prof.c3;
            vb_sel = i_prof.vm;
        end else begin
            pb_sel = i_goal;
            vb_sel = i_ev;
        end
    end

    always_comb begin
        m_g  = r1_g * $signed({1'b0, r1_u});
        m_h  = r1_h * $signed({1'b0, r1_u});
        comb = (COMB_W'(r3_phi) <<< WORD_BITS) + COMB_W'({1'b0, r3_plo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_err <= i_prof.err;
        r1_u   <= u_sel;
        r1_g   <= g_sel;
        r1_h   <= h_sel;
        r1_pb  <= pb_sel;
        r1_vb  <= vb_sel;

        r2_err <= r1_err;
        r2_u   <= r1_u;
        r2_a   <= m_g[FRAC_BITS +: A_W];
        r2_hu  <= m_h[FRAC_BITS +: A_W];
        r2_pb  <= r1_pb;
        r2_vb  <= r1_vb;

        // squared term split into high and low halves of the gain product
        r3_err <= r2_err;
        r3_phi <= $signed(r2_a[A_W-1:WORD_BITS]) * $signed({1'b0, r2_u});
        r3_plo <= r2_a[WORD_BITS-1:0] * r2_u;
        r3_hu  <= r2_hu;
        r3_pb  <= r2_pb;
        r3_v   <= sat_word(SUM_W'(r2_a) + SUM_W'(r2_vb));

        r4_err <= r3_err;
        r4_b   <= SUM_W'(comb >>> (FRAC_BITS + 1));
        r4_lin <= SUM_W'(r3_hu) + SUM_W'(r3_pb);
        r4_v   <= r3_v;

        r5_err <= r4_err;
        r5_v   <= r4_v;
        r5_p   <= sat_word(r4_b + r4_lin);
    end

    assign o_valid = r5_valid;
    assign o_speed = r5_v;
    assign o_place = r5_p;
    assign o_err   = r5_err;

endmodule
